// ===== rtl/srr_pkg.sv =====
package srr_pkg;

  // packet type codes
  localparam logic [1:0] PKT_START = 2'd0;
  localparam logic [1:0] PKT_END   = 2'd1;
  localparam logic [1:0] PKT_DATA  = 2'd2;
  localparam logic [1:0] PKT_OTHER = 2'd3;

  // result kind codes
  localparam logic KIND_ACK   = 1'b0;
  localparam logic KIND_DELIV = 1'b1;

  localparam logic [5:0]  WinReset = 6'd8;
  localparam logic [15:0] MaxBody  = 16'd2048;

  typedef struct packed {
    logic [1:0]  pkt_type;
    logic [31:0] seq_num;
    logic [11:0] pay_len;
    logic        crc_ok;
  } pkt_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] out_seq;
    logic [11:0] out_len;
    logic [4:0]  slot_index;
    logic [15:0] file_index;
    logic        last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DECIDE,
    ST_WALK,
    ST_DELIV,
    ST_ACK
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic eval;
    logic set_started;
    logic write_slot;
    logic walk_init;
    logic rd;
    logic deliver;
    logic ack;
    logic clear_end;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] pkt_type;
    logic       data_started;
    logic       lt_base;
    logic       in_win;
    logic       present;
    logic       bad;
    logic       at_base;
    logic       walk_ok;
  } dp_status_t;

endpackage

// ===== rtl/srr_ctrl.sv =====
module srr_ctrl
  import srr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  logic accept_new;
  assign accept_new = status_i.pkt_type == PKT_DATA && !status_i.lt_base && status_i.in_win
                      && !status_i.present && !status_i.bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_EVAL;
      end
      ST_EVAL: state_d = ST_DECIDE;
      ST_DECIDE: begin
        unique case (status_i.pkt_type)
          PKT_START: state_d = status_i.data_started ? ST_IDLE : ST_ACK;
          PKT_END:   state_d = ST_ACK;
          PKT_DATA: begin
            priority if (status_i.lt_base) state_d = ST_ACK;
            else if (!status_i.in_win)     state_d = ST_IDLE;
            else if (status_i.present)     state_d = ST_ACK;
            else if (status_i.bad)         state_d = ST_IDLE;
            else if (status_i.at_base)     state_d = ST_WALK;
            else                           state_d = ST_ACK;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_WALK:  state_d = status_i.walk_ok ? ST_DELIV : ST_ACK;
      ST_DELIV: state_d = ST_WALK;
      ST_ACK:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ST_EVAL: cmd_o.eval = 1'b1;
      ST_DECIDE: begin
        cmd_o.set_started = status_i.pkt_type == PKT_DATA;
        cmd_o.write_slot  = accept_new;
        cmd_o.walk_init   = accept_new;
      end
      ST_WALK:  cmd_o.rd = status_i.walk_ok;
      ST_DELIV: cmd_o.deliver = 1'b1;
      ST_ACK: begin
        cmd_o.ack       = 1'b1;
        cmd_o.clear_end = status_i.pkt_type == PKT_END;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== rtl/srr_datapath.sv =====
module srr_datapath
  import srr_pkg::*;
#(
  parameter int unsigned WINDOW_SLOTS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [5:0] cfg_data_i,
  input  pkt_t       pkt_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  output logic       res_strobe_o,
  output res_t       res_o
);

  localparam int unsigned SW = $clog2(WINDOW_SLOTS);
  localparam int unsigned CW = $clog2(WINDOW_SLOTS + 1);
  localparam logic [6:0]    SlotsW  = 7'(WINDOW_SLOTS);
  localparam logic [SW:0]   SlotsX  = (SW + 1)'(WINDOW_SLOTS);
  localparam logic [SW-1:0] LastSlot = SW'(WINDOW_SLOTS - 1);

  logic [5:0]              win_size_q;
  pkt_t                    in_q;
  logic [31:0]             base_q;
  logic [SW-1:0]           base_slot_q;
  logic [WINDOW_SLOTS-1:0] present_q;
  logic                    started_q;
  logic [15:0]             count_q;
  logic [CW-1:0]           walk_cnt_q;
  logic                    lt_q, in_win_q, at_base_q;
  logic [SW-1:0]           slot_q;
  logic [11:0]             len_mem [WINDOW_SLOTS];
  logic [11:0]             rdata_q;
  logic                    strobe_q;
  res_t                    res_q;

  // effective window, clipped at the slot count
  logic [6:0]    win_w;
  logic [CW-1:0] win;
  assign win_w = ({1'b0, win_size_q} > SlotsW) ? SlotsW : {1'b0, win_size_q};
  assign win   = CW'(win_w);

  // window checks, edge compare without wrap
  logic [32:0]   edge_sum;
  logic [31:0]   diff;
  logic [SW:0]   slot_sum;
  logic [SW-1:0] slot_d;
  assign edge_sum = {1'b0, base_q} + 33'(win);
  assign diff     = in_q.seq_num - base_q;
  assign slot_sum = {1'b0, base_slot_q} + {1'b0, diff[SW-1:0]};
  assign slot_d   = (slot_sum >= SlotsX) ? SW'(slot_sum - SlotsX) : slot_sum[SW-1:0];

  logic [SW-1:0] next_base_slot;
  assign next_base_slot = (base_q == '1 || base_slot_q == LastSlot) ? '0 : base_slot_q + 1'b1;

  assign status_o.pkt_type     = in_q.pkt_type;
  assign status_o.data_started = started_q;
  assign status_o.lt_base      = lt_q;
  assign status_o.in_win       = in_win_q;
  assign status_o.present      = present_q[slot_q];
  assign status_o.bad          = !in_q.crc_ok || (16'(in_q.pay_len) > MaxBody);
  assign status_o.at_base      = at_base_q;
  assign status_o.walk_ok      = present_q[base_slot_q] && (walk_cnt_q < win);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q  <= WinReset;
      base_q      <= '0;
      base_slot_q <= '0;
      present_q   <= '0;
      started_q   <= 1'b0;
      count_q     <= '0;
      walk_cnt_q  <= '0;
      strobe_q    <= 1'b0;
    end else begin
      strobe_q <= cmd_i.deliver || cmd_i.ack;
      if (cfg_valid_i) win_size_q <= cfg_data_i;
      if (cmd_i.set_started) started_q <= 1'b1;
      if (cmd_i.write_slot) present_q[slot_q] <= 1'b1;
      if (cmd_i.walk_init) walk_cnt_q <= '0;
      if (cmd_i.deliver) begin
        present_q[base_slot_q] <= 1'b0;
        base_q      <= base_q + 32'd1;
        base_slot_q <= next_base_slot;
        walk_cnt_q  <= walk_cnt_q + 1'b1;
      end
      if (cmd_i.clear_end) begin
        base_q      <= '0;
        base_slot_q <= '0;
        present_q   <= '0;
        started_q   <= 1'b0;
        count_q     <= count_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= pkt_i;
    if (cmd_i.eval) begin
      lt_q      <= in_q.seq_num < base_q;
      in_win_q  <= {1'b0, in_q.seq_num} < edge_sum;
      at_base_q <= in_q.seq_num == base_q;
      slot_q    <= slot_d;
    end
    if (cmd_i.write_slot) len_mem[slot_q] <= in_q.pay_len;
    if (cmd_i.rd) rdata_q <= len_mem[base_slot_q];
    if (cmd_i.deliver) begin
      res_q.kind       <= KIND_DELIV;
      res_q.out_seq    <= base_q;
      res_q.out_len    <= rdata_q;
      res_q.slot_index <= 5'(base_slot_q);
      res_q.file_index <= count_q;
      res_q.last       <= 1'b0;
    end else if (cmd_i.ack) begin
      res_q.kind       <= KIND_ACK;
      res_q.out_seq    <= in_q.seq_num;
      res_q.out_len    <= '0;
      res_q.slot_index <= '0;
      res_q.file_index <= count_q;
      res_q.last       <= 1'b1;
    end
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

// ===== rtl/selective_repeat_receiver.sv =====
// an ack that releases nothing follows start through the states EVAL, DECIDE and ACK; dropped or
// ignored items return to IDLE from DECIDE; releasing payloads adds, for each one, a WALK state
// (presence check and slot length memory read) and a DELIV state, plus one closing WALK presence
// check before ACK; busy is low only in IDLE, so no new item is taken before the last is through
// results are single-cycle strobes; the receiver cannot stall them
// reset (async, active low) clears base, presence bits, counters, window size to 8; lengths kept
module selective_repeat_receiver
  import srr_pkg::*;
#(
  parameter int unsigned WINDOW_SLOTS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  pkt_t       pkt_i,
  output logic       res_strobe_o,
  output res_t       res_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [5:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  srr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  srr_datapath #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .pkt_i        (pkt_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

endmodule

// ===== sim/selective_repeat_receiver_tb.sv =====
module selective_repeat_receiver_tb;
  import srr_pkg::*;

  localparam int unsigned SLOTS = 32;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS = 45;

  // tracks the receive window and predicts acks and in-order deliveries
  class window_tracker;
    logic [5:0]  win_size;
    logic [31:0] base;
    bit          present [SLOTS];
    logic [11:0] length [SLOTS];
    bit          started;
    logic [15:0] transfers;
    res_t        awaited[$];
    int unsigned errors;

    function new();
      win_size  = WinReset;
      base      = '0;
      present   = '{default: 1'b0};
      started   = 1'b0;
      transfers = '0;
      errors    = 0;
    endfunction

    function int unsigned eff_win();
      return (win_size > SLOTS) ? SLOTS : int'(win_size);
    endfunction

    task report(input string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    function void queue_due(input res_t r);
      awaited = {awaited, r};
    endfunction

    function void take_packet(input pkt_t p);
      res_t        ack;
      res_t        dlv;
      int unsigned w;
      int unsigned i;
      logic [31:0] s;
      logic [4:0]  sl;
      w = eff_win();
      ack = '0;
      ack.kind = KIND_ACK;
      ack.out_seq = p.seq_num;
      ack.file_index = transfers;
      ack.last = 1'b1;
      case (p.pkt_type)
        PKT_START: begin
          // a start once data has flowed is silently ignored
          if (!started) queue_due(ack);
        end
        PKT_END: begin
          queue_due(ack);
          base = '0;
          present = '{default: 1'b0};
          started = 1'b0;
          transfers = transfers + 16'd1;
        end
        PKT_DATA: begin
          started = 1'b1;
          sl = 5'(p.seq_num % SLOTS);
          if (p.seq_num < base) begin
            queue_due(ack);
          end else if ({1'b0, p.seq_num} >= {1'b0, base} + 33'(w)) begin
            // beyond the window edge, dropped
          end else if (present[sl]) begin
            queue_due(ack);
          end else if (p.crc_ok && p.pay_len <= MaxBody) begin
            present[sl] = 1'b1;
            length[sl] = p.pay_len;
            if (p.seq_num == base) begin
              for (i = 0; i < w; i++) begin
                s = base + i;
                if (!present[5'(s % SLOTS)]) break;
                dlv = '0;
                dlv.kind = KIND_DELIV;
                dlv.out_seq = s;
                dlv.out_len = length[5'(s % SLOTS)];
                dlv.slot_index = 5'(s % SLOTS);
                dlv.file_index = transfers;
                dlv.last = 1'b0;
                queue_due(dlv);
                present[5'(s % SLOTS)] = 1'b0;
              end
              base = base + i;
            end
            queue_due(ack);
          end
        end
        PKT_OTHER: begin
        end
        default: begin
        end
      endcase
    endfunction

    task check_out(input res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing due: kind %0d seq %0d", got.kind, got.out_seq));
        return;
      end
      want = awaited.pop_front();
      if (got.kind != want.kind)
        report($sformatf("seq %0d kind %0d, due %0d", want.out_seq, got.kind, want.kind));
      if (got.out_seq != want.out_seq)
        report($sformatf("out_seq %0d, due %0d", got.out_seq, want.out_seq));
      if (got.out_len != want.out_len)
        report($sformatf("seq %0d out_len %0d, due %0d", want.out_seq, got.out_len,
                         want.out_len));
      if (got.slot_index != want.slot_index)
        report($sformatf("seq %0d slot_index %0d, due %0d", want.out_seq, got.slot_index,
                         want.slot_index));
      if (got.file_index != want.file_index)
        report($sformatf("seq %0d file_index %0d, due %0d", want.out_seq, got.file_index,
                         want.file_index));
      if (got.last != want.last)
        report($sformatf("seq %0d last %0d, due %0d", want.out_seq, got.last, want.last));
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  pkt_t       pkt_i = '0;
  logic       res_strobe_o;
  res_t       res_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [5:0] cfg_data_i = '0;

  window_tracker track = new();
  int unsigned   sent = 0;
  int unsigned   idle_cycles = 0;

  selective_repeat_receiver #(
    .WINDOW_SLOTS(SLOTS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pkt_i       (pkt_i),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_strobe_o) track.check_out(res_o);
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || res_strobe_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("selective_repeat_receiver verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic pkt_t make_pkt(input logic [1:0] kind, input logic [31:0] seq,
                                    input logic [11:0] len, input logic crc);
    pkt_t p;
    p.pkt_type = kind;
    p.seq_num = seq;
    p.pay_len = len;
    p.crc_ok = crc;
    return p;
  endfunction

  task automatic hold_off(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // start stays high across back-to-back items; callers lower it before going quiet
  task automatic push_header(input pkt_t p, input int unsigned gap_pct);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) hold_off($urandom_range(1, 16));
    start <= 1'b1;
    pkt_i <= p;
    do @(posedge clk_i); while (busy);
    track.take_packet(p);
    if (p.pkt_type != PKT_OTHER) sent++;
  endtask

  // dropped items give no result, so allow the block to finish after the last one
  task automatic settle();
    start <= 1'b0;
    while (track.awaited.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [5:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    track.win_size = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_transfer(input int unsigned gap_pct);
    pkt_t          p;
    logic [31:0]   b;
    logic [31:0]   tmp;
    logic [31:0]   order[$];
    int unsigned   w;
    int unsigned   j;
    int unsigned   t;
    int unsigned   pick;
    w = track.eff_win();
    repeat ($urandom_range(0, 2))
      push_header(make_pkt(PKT_START, $urandom(), 12'($urandom()), 1'($urandom())), gap_pct);
    if (w > 1 && $urandom_range(0, 3) == 0) begin
      // fill the window out of order with the base last, so it all drains in one walk
      b = track.base;
      for (j = 1; j < w; j++) order = {order, b + j};
      for (j = order.size(); j > 1; j--) begin
        t = $urandom_range(0, j - 1);
        tmp = order[t];
        order[t] = order[j - 1];
        order[j - 1] = tmp;
      end
      order = {order, b};
      foreach (order[n])
        push_header(make_pkt(PKT_DATA, order[n], 12'($urandom_range(0, MaxBody)), 1'b1),
                    gap_pct);
    end else begin
      repeat ($urandom_range(4, 16)) begin
        pick = $urandom_range(0, 99);
        p = make_pkt(2'($urandom()), $urandom(), 12'($urandom()), 1'($urandom()));
        if (pick < 70) begin
          p.pkt_type = PKT_DATA;
          p.seq_num = track.base + $urandom_range(0, w + 1);
          if ($urandom_range(0, 19) != 0) p.pay_len = 12'($urandom_range(0, MaxBody));
          p.crc_ok = ($urandom_range(0, 9) != 0);
        end else if (pick < 80) begin
          p.pkt_type = PKT_DATA;
          p.seq_num = (track.base == 0) ? 32'd0 : $urandom_range(0, track.base - 1);
        end else if (pick < 90) begin
          p.pkt_type = PKT_DATA;
        end else if (pick < 95) begin
          p.pkt_type = PKT_START;
        end
        push_header(p, gap_pct);
      end
    end
    if ($urandom_range(0, 9) != 0)
      push_header(make_pkt(PKT_END, $urandom(), 12'($urandom()), 1'($urandom())), gap_pct);
  endtask

  initial begin
    logic [5:0]  windows [8];
    int unsigned goal;
    int unsigned gap_pct;
    bit          calm;
    windows = '{6'd0, 6'd1, 6'd32, 6'd63, 6'd8, 6'd0, 6'd0, 6'd2};
    windows[5] = 6'($urandom_range(2, 31));
    windows[6] = 6'($urandom_range(1, 63));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk through the window rules with the reset window of 8
    push_header(make_pkt(PKT_START, 32'd0, 12'd0, 1'b1), 0);
    push_header(make_pkt(PKT_OTHER, 32'd5, 12'd9, 1'b1), 0);
    push_header(make_pkt(PKT_DATA, 32'd1, 12'd100, 1'b1), 0);
    push_header(make_pkt(PKT_DATA, 32'd0, 12'd2048, 1'b1), 0);
    push_header(make_pkt(PKT_DATA, 32'd0, 12'd7, 1'b1), 0);
    push_header(make_pkt(PKT_DATA, 32'd2, 12'd5, 1'b0), 0);
    push_header(make_pkt(PKT_DATA, 32'd2, 12'd2049, 1'b1), 0);
    push_header(make_pkt(PKT_DATA, 32'd2, 12'hfff, 1'b1), 0);
    push_header(make_pkt(PKT_DATA, 32'd10, 12'd3, 1'b1), 0);
    push_header(make_pkt(PKT_DATA, 32'd9, 12'd0, 1'b1), 0);
    push_header(make_pkt(PKT_DATA, 32'd9, 12'hfff, 1'b0), 0);
    push_header(make_pkt(PKT_START, 32'hffff_ffff, 12'hfff, 1'b1), 0);
    push_header(make_pkt(PKT_DATA, 32'hffff_ffff, 12'hfff, 1'b1), 0);
    push_header(make_pkt(PKT_DATA, 32'd2, 12'd1, 1'b1), 0);
    push_header(make_pkt(PKT_END, 32'hffff_ffff, 12'hfff, 1'b0), 0);
    push_header(make_pkt(PKT_START, 32'haaaa_5555, 12'h555, 1'b0), 0);
    push_header(make_pkt(PKT_DATA, 32'd0, 12'h555, 1'b1), 0);
    push_header(make_pkt(PKT_END, 32'd0, 12'd0, 1'b1), 0);
    settle();

    goal = sent;
    foreach (windows[ph]) begin
      set_window(windows[ph]);
      calm = (ph >= 6);
      goal += PHASE_ITEMS;
      while (sent < goal) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 15;
          default: gap_pct = 50;
        endcase
        run_transfer(calm ? 0 : gap_pct);
      end
      settle();
    end

    if (track.awaited.size() != 0)
      track.report($sformatf("%0d results never arrived", track.awaited.size()));
    if (track.errors == 0) begin
      $display("selective_repeat_receiver verification clean");
    end else begin
      $display("selective_repeat_receiver verification failed");
    end
    $finish;
  end

endmodule
